/* hdl/ddlf_pkg.sv */
// Shared types, widths and helpers for the dual delayed linear fade ramp.
// Used by ddlf_tick, ddlf_div and the top level; depends on nothing.
`timescale 1ns / 1ps

package ddlf_pkg;

  localparam int unsigned LEVEL_FRAC_BITS = 16;
  localparam int unsigned TIME_BITS       = 24;
  localparam int unsigned LVL_W           = LEVEL_FRAC_BITS + 1;
  localparam int unsigned PROD_W          = LVL_W + TIME_BITS;

  // Fixed field widths of the stream beats
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned DUR_W   = 24;
  localparam int unsigned IN_W    = 88;
  localparam int unsigned OUT_W   = 56;

  typedef logic [LVL_W-1:0]     level_t;
  typedef logic [TIME_BITS-1:0] time_t;

  localparam level_t LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  typedef struct packed {
    level_t start;
    level_t target;
    level_t level;
    time_t  wait_left;
    time_t  elapsed;
    time_t  length;
    logic   running;
  } chan_t;

  // Outcome of the tick front end for one channel
  typedef struct packed {
    logic   advance;  // ramp still running: interpolate through the divider
    logic   finish;   // fade reached its end on this tick
    logic   down;     // ramp falls from start to target
    level_t diff;     // magnitude of target minus start
  } tick_res_t;

  function automatic level_t clamp_level(input logic [ALPHA_W-1:0] v);
    level_t r;
    if (v > ALPHA_W'(LVL_ONE)) begin
      r = LVL_ONE;
    end else begin
      r = LVL_W'(v);
    end
    return r;
  endfunction

endpackage

/* hdl/ddlf_tick.sv */
// Tick front end for one fade channel: delay countdown, elapsed time update,
// finish detection and ramp direction. Depends on ddlf_pkg.
`timescale 1ns / 1ps

module ddlf_tick (
  input  ddlf_pkg::chan_t     chan_i,
  input  ddlf_pkg::time_t     dt_i,
  output ddlf_pkg::chan_t     chan_o,
  output ddlf_pkg::tick_res_t res_o
);

  ddlf_pkg::time_t             run_dt;
  logic [ddlf_pkg::TIME_BITS:0] sum;
  ddlf_pkg::time_t             sum_sat;

  always_comb begin
    chan_o = chan_i;
    res_o  = '0;
    run_dt = dt_i;
    sum    = '0;
    sum_sat = '0;
    if (chan_i.running) begin
      // Spend the delay first; only the leftover time moves the ramp
      if (chan_i.wait_left != '0) begin
        if (chan_i.wait_left > dt_i) begin
          chan_o.wait_left = chan_i.wait_left - dt_i;
          run_dt = '0;
        end else begin
          run_dt = dt_i - chan_i.wait_left;
          chan_o.wait_left = '0;
        end
      end
      if (run_dt != '0) begin
        sum     = {1'b0, chan_i.elapsed} + {1'b0, run_dt};
        sum_sat = sum[ddlf_pkg::TIME_BITS] ? '1 : sum[ddlf_pkg::TIME_BITS-1:0];
        chan_o.elapsed = sum_sat;
        if (chan_i.length == '0 || sum_sat >= chan_i.length) begin
          chan_o.level   = chan_i.target;
          chan_o.running = 1'b0;
          res_o.finish   = 1'b1;
        end else begin
          res_o.advance = 1'b1;
          res_o.down    = chan_i.target < chan_i.start;
          res_o.diff    = res_o.down ? chan_i.start - chan_i.target
                                     : chan_i.target - chan_i.start;
        end
      end
    end
  end

endmodule

/* hdl/ddlf_div.sv */
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
// The high part of the dividend must be below the divisor. Depends on ddlf_pkg.
`timescale 1ns / 1ps

module ddlf_div #(
  parameter int unsigned QUO_W  = ddlf_pkg::LVL_W,
  parameter int unsigned DIVR_W = ddlf_pkg::TIME_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [QUO_W+DIVR_W-1:0] dividend_i,
  input  logic [DIVR_W-1:0]       divisor_i,
  output logic                    done_o,
  output logic [QUO_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVR_W-1:0] rem_q;
  logic [DIVR_W-1:0] div_q;
  logic [QUO_W-1:0]  quo_q;

  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Pulse done on the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[QUO_W+DIVR_W-1:QUO_W];
      quo_q <= dividend_i[QUO_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/dual_delayed_linear_fade_ramp_core.sv */
// Top level of the dual delayed linear fade ramp: command sequencer, channel
// state and output register. Depends on ddlf_pkg, ddlf_tick and ddlf_div.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one beat per command. tuser carries the command code (tick,
//   start screen fade, start title fade, set screen level, set title level);
//   tdata carries time step, level, duration and delay.
//   Master stream: one beat per command with both levels, both busy flags,
//   the screen-finish pulse with its level and the overlay release flag.
// Sequencing
//   Start, set and unknown commands: the execute state applies the command
//   and the output state registers the result; the next beat is taken once
//   the core is back in idle. A tick runs the tick front end on the screen
//   channel, then on the title channel; a channel whose ramp is still moving
//   also passes through a multiply step, a divider load, the serial divide
//   and a write-back step. Both channels use the single shared divider.
// Reset
//   Both channels return to level zero, idle, with no beat pending.
// Back-pressure
//   The result waits in the output register while the master side stalls;
//   the next command is still taken and processed, and it holds in the final
//   state until the register frees up.

module dual_delayed_linear_fade_ramp_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: time_step[15:0], alpha_value[32:16], duration_value[56:33],
  //        delay_value[80:57], zero fill [87:81]
  input  logic [ddlf_pkg::IN_W-1:0]      s_axis_tdata_i,
  // tuser: command[2:0]
  input  logic [ddlf_pkg::CMD_W-1:0]     s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: screen_level[16:0], title_level[33:17], screen_busy[34],
  //        title_busy[35], screen_done[36], done_level[53:37],
  //        overlay_release[54], zero fill [55]
  output logic [ddlf_pkg::OUT_W-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START_SCR = 3'd1,
    CMD_START_TTL = 3'd2,
    CMD_SET_SCR   = 3'd3,
    CMD_SET_TTL   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic CH_SCR = 1'b0;
  localparam logic CH_TTL = 1'b1;

  // Input beat fields
  logic [ddlf_pkg::DT_W-1:0]    in_dt;
  logic [ddlf_pkg::ALPHA_W-1:0] in_alpha;
  logic [ddlf_pkg::DUR_W-1:0]   in_dur;
  logic [ddlf_pkg::DUR_W-1:0]   in_dly;

  assign in_dt    = s_axis_tdata_i[15:0];
  assign in_alpha = s_axis_tdata_i[32:16];
  assign in_dur   = s_axis_tdata_i[56:33];
  assign in_dly   = s_axis_tdata_i[80:57];

  state_e                       state_q;
  logic [ddlf_pkg::CMD_W-1:0]   cmd_q;
  ddlf_pkg::time_t              dt_q;
  ddlf_pkg::level_t             alpha_q;
  ddlf_pkg::time_t              dur_q;
  ddlf_pkg::time_t              dly_q;
  logic                         ch_q;
  ddlf_pkg::chan_t              chan_q [2];

  logic                         done_q;
  ddlf_pkg::level_t             done_lvl_q;
  logic                         release_q;

  ddlf_pkg::level_t             diff_q;
  logic                         down_q;
  logic [ddlf_pkg::PROD_W-1:0]  prod_q;
  logic                         div_go_q;

  logic                         m_valid_q;
  logic [ddlf_pkg::OUT_W-1:0]   m_data_q;

  // Tick front end on the selected channel
  ddlf_pkg::chan_t              cur_chan;
  ddlf_pkg::chan_t              tick_chan;
  ddlf_pkg::tick_res_t          tick_res;

  assign cur_chan = chan_q[ch_q];

  ddlf_tick u_tick (
    .chan_i (cur_chan),
    .dt_i   (dt_q),
    .chan_o (tick_chan),
    .res_o  (tick_res)
  );

  // Shared serial divider: (diff * elapsed) / length
  logic                         div_done;
  ddlf_pkg::level_t             div_quo;

  ddlf_div #(
    .QUO_W  (ddlf_pkg::LVL_W),
    .DIVR_W (ddlf_pkg::TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (prod_q),
    .divisor_i  (cur_chan.length),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Interpolated level from the quotient
  logic [ddlf_pkg::LVL_W:0]     up_sum;
  ddlf_pkg::level_t             ramp_level;

  always_comb begin
    up_sum = {1'b0, cur_chan.start} + {1'b0, div_quo};
    if (down_q) begin
      ramp_level = (div_quo > cur_chan.start) ? '0 : cur_chan.start - div_quo;
    end else if (up_sum > {1'b0, ddlf_pkg::LVL_ONE}) begin
      ramp_level = ddlf_pkg::LVL_ONE;
    end else begin
      ramp_level = up_sum[ddlf_pkg::LVL_W-1:0];
    end
  end

  // Start and set decoding for the command in hand
  ddlf_pkg::level_t             cmd_lvl;
  logic                         cmd_ch;
  logic                         start_skip;

  assign cmd_lvl = ddlf_pkg::clamp_level(ddlf_pkg::ALPHA_W'(alpha_q));
  assign cmd_ch  = (cmd_q == CMD_START_TTL || cmd_q == CMD_SET_TTL) ? CH_TTL : CH_SCR;
  assign start_skip = (chan_q[cmd_ch].running && chan_q[cmd_ch].target == cmd_lvl) ||
                      (!chan_q[cmd_ch].running && chan_q[cmd_ch].level == cmd_lvl);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= '0;
      ch_q       <= CH_SCR;
      chan_q[0]  <= '0;
      chan_q[1]  <= '0;
      done_q     <= 1'b0;
      done_lvl_q <= '0;
      release_q  <= 1'b0;
      down_q     <= 1'b0;
      div_go_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      // Kick the divider as the product is registered
      div_go_q <= (state_q == ST_MUL);
      // Drop the pending beat once the master side takes it; the output
      // state reloads the register itself
      if (m_valid_q && m_axis_tready_i && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q      <= s_axis_tuser_i;
            done_q     <= 1'b0;
            done_lvl_q <= '0;
            release_q  <= 1'b0;
            ch_q       <= CH_SCR;
            state_q    <= (s_axis_tuser_i == CMD_TICK) ? ST_TICK : ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_q)
            CMD_START_SCR, CMD_START_TTL: begin
              if (!start_skip) begin
                chan_q[cmd_ch].start     <= chan_q[cmd_ch].level;
                chan_q[cmd_ch].target    <= cmd_lvl;
                chan_q[cmd_ch].length    <= dur_q;
                chan_q[cmd_ch].wait_left <= dly_q;
                chan_q[cmd_ch].elapsed   <= '0;
                chan_q[cmd_ch].running   <= 1'b1;
              end
            end
            CMD_SET_SCR, CMD_SET_TTL: begin
              chan_q[cmd_ch].running   <= 1'b0;
              chan_q[cmd_ch].wait_left <= '0;
              chan_q[cmd_ch].elapsed   <= '0;
              chan_q[cmd_ch].start     <= cmd_lvl;
              chan_q[cmd_ch].target    <= cmd_lvl;
              chan_q[cmd_ch].level     <= cmd_lvl;
              // Release when both levels end up at zero
              if (cmd_ch == CH_SCR) begin
                release_q <= (cmd_lvl == '0) && (chan_q[1].level == '0);
              end else begin
                release_q <= (cmd_lvl == '0) && (chan_q[0].level == '0);
              end
            end
            default: begin
            end
          endcase
          state_q <= ST_OUT;
        end
        ST_TICK: begin
          chan_q[ch_q] <= tick_chan;
          if (tick_res.finish && ch_q == CH_SCR) begin
            // Title level here is still the value from before this tick
            done_q     <= 1'b1;
            done_lvl_q <= cur_chan.target;
            release_q  <= (cur_chan.target == '0) && (chan_q[1].level == '0);
          end
          if (tick_res.advance) begin
            diff_q  <= tick_res.diff;
            down_q  <= tick_res.down;
            state_q <= ST_MUL;
          end else if (ch_q == CH_SCR) begin
            ch_q <= CH_TTL;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_MUL: begin
          prod_q  <= {{ddlf_pkg::TIME_BITS{1'b0}}, diff_q} *
                     {{ddlf_pkg::LVL_W{1'b0}}, cur_chan.elapsed};
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            chan_q[ch_q].level <= ramp_level;
            if (ch_q == CH_SCR) begin
              ch_q    <= CH_TTL;
              state_q <= ST_TICK;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          // Hold until the output register is free or being emptied
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {1'b0, release_q, done_lvl_q, done_q,
                          chan_q[1].running, chan_q[0].running,
                          chan_q[1].level, chan_q[0].level};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload of the accepted command beat
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      dt_q    <= ddlf_pkg::time_t'(in_dt);
      alpha_q <= ddlf_pkg::level_t'(in_alpha);
      dur_q   <= ddlf_pkg::time_t'(in_dur);
      dly_q   <= ddlf_pkg::time_t'(in_dly);
    end
  end

endmodule
